@@ hdl/jbs_pkg.sv @@
// shared constants and types for the jitter buffer sizer
package jbs_pkg;
    localparam int WINDOW_DEPTH = 150;
    localparam int CNT_W        = $clog2(WINDOW_DEPTH);

    localparam logic [1:0] OP_PACKET = 2'd0;
    localparam logic [1:0] OP_LATE   = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_RESET  = 2'd3;

    localparam logic [1:0] ST_NORMAL = 2'd0;
    localparam logic [1:0] ST_GOOD   = 2'd1;
    localparam logic [1:0] ST_BAD    = 2'd2;

    localparam logic [2:0] REG_MIN_SIZE   = 3'd0;
    localparam logic [2:0] REG_MAX_SIZE   = 3'd1;
    localparam logic [2:0] REG_HOLD_MS    = 3'd2;
    localparam logic [2:0] REG_STEP_LIMIT = 3'd3;
    localparam logic [2:0] REG_WEIGHT     = 3'd4;

    localparam logic [31:0] FILL_INIT = 32'h7FFF_FFFF;
    localparam logic [45:0] ROUND_ADD = 46'd2560;

    typedef logic [31:0] t_word;
endpackage

@@ hdl/jbs_if.sv @@
// channel interfaces: input item, result item, register write
interface jbs_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [31:0] media_timestamp;
    logic [31:0] arrival_time;
    logic [31:0] event_time;
    logic [7:0]  current_size;
    modport source (output valid, opcode, media_timestamp, arrival_time, event_time,
                    current_size, input ready);
    modport sink (input valid, opcode, media_timestamp, arrival_time, event_time,
                  current_size, output ready);
endinterface

interface jbs_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] transit_delta;
    logic [7:0]         next_size;
    logic [1:0]         link_status;
    logic signed [31:0] window_max;
    modport source (output valid, transit_delta, next_size, link_status, window_max,
                    input ready);
    modport sink (input valid, transit_delta, next_size, link_status, window_max,
                  output ready);
endinterface

interface jbs_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/jbs_cell.sv @@
// one window cell: an entry and its valid bit, shifted from its neighbour
module jbs_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_clr,
    input  logic               i_shift,
    input  jbs_pkg::t_word     i_val,
    input  logic               i_vld,
    output jbs_pkg::t_word     o_val,
    output logic               o_vld
);
    import jbs_pkg::*;

    t_word r_val;
    logic  r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_vld <= 1'b0;
        end else if (i_shift) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_val <= i_val;
        end
    end

    assign o_val = r_val;
    assign o_vld = r_vld;
endmodule

@@ hdl/adaptive_jitter_buffer_sizer_unit.sv @@
// jitter buffer sizer: each item runs a full rotation of the window cell chain that
// finds the maximum; a size query then goes on through the weight multiply, the divide
// stage and the decision; registers are always ready and are to be written only while
// idle by the user, the block itself does not enforce it; a result waits in the output
// register while the next word is taken
module adaptive_jitter_buffer_sizer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    jbs_in_if.sink      i_in,
    jbs_out_if.source   o_out,
    jbs_cfg_if.sink     i_cfg
);
    import jbs_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_DEC  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]  r_state, n_state;
    logic [1:0]  r_op;
    t_word       r_ts, r_arr, r_ev;
    logic [7:0]  r_cur;
    logic [7:0]  r_min, r_max_size, r_limit;
    logic [15:0] r_hold;
    logic [11:0] r_weight;
    t_word       r_last_ts, r_last_arr, r_sum, r_fill, r_late, r_good_since;
    logic [1:0]  r_status;
    logic [CNT_W-1:0] r_cnt;
    t_word       r_max;
    logic        r_have;
    logic signed [44:0] r_prod;
    logic [8:0]  r_tgt;
    t_word       r_delta;
    logic [7:0]  r_next;
    logic        r_ovld;
    t_word       r_odelta, r_omax;
    logic [7:0]  r_onext;
    logic [1:0]  r_ostat;

    t_word cv [WINDOW_DEPTH];
    logic  cb [WINDOW_DEPTH];

    logic  w_push, w_shift, w_clr;
    t_word w_delta, w_sum, w_entry, w_head;
    logic  w_head_vld;

    assign w_delta = (r_arr - r_last_arr) - (r_ts - r_last_ts);
    assign w_sum   = r_sum + w_delta;
    assign w_entry = (r_fill == FILL_INIT) ? w_sum : w_sum - r_fill;
    assign w_push  = (r_state == S_EXEC) && (r_op == OP_PACKET) && (r_last_ts != '0);
    assign w_shift = w_push || (r_state == S_SCAN);
    assign w_clr   = (r_state == S_EXEC) && (r_op == OP_RESET);
    assign w_head  = w_push ? w_entry : cv[WINDOW_DEPTH-1];
    assign w_head_vld = w_push ? 1'b1 : cb[WINDOW_DEPTH-1];

    for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            jbs_cell u_cell (.i_clk, .i_rst_n, .i_clr(w_clr), .i_shift(w_shift),
                             .i_val(w_head), .i_vld(w_head_vld),
                             .o_val(cv[g]), .o_vld(cb[g]));
        end else begin : g_next
            jbs_cell u_cell (.i_clk, .i_rst_n, .i_clr(w_clr), .i_shift(w_shift),
                             .i_val(cv[g-1]), .i_vld(cb[g-1]),
                             .o_val(cv[g]), .o_vld(cb[g]));
        end
    end

    // target from the weighted maximum
    logic signed [45:0] w_num;
    logic [35:0]        w_q;
    logic [22:0]        w_recip;
    logic [8:0]         w_tgt;

    always_comb begin
        w_num   = 46'(r_prod) + $signed(ROUND_ADD);
        w_q     = 36'(w_num >>> 10);
        w_recip = 23'({12'd0, w_q[10:0]} * 23'd3277);
        if (w_num < 0) begin
            w_tgt = '0;
        end else if (w_q >= 36'd1280) begin
            w_tgt = 9'd256;
        end else begin
            w_tgt = 9'(w_recip >> 14);
        end
    end

    // size decision
    logic        w_bad, w_good, w_hold_ok;
    logic [7:0]  w_step, w_dn, w_next;
    logic [1:0]  w_stat;
    t_word       w_gs;

    always_comb begin
        w_bad     = r_tgt > {1'b0, r_cur};
        w_good    = !w_bad && ((r_cur == '0) || (r_tgt < ({1'b0, r_cur} - 9'd1)));
        w_hold_ok = ((r_ev - r_good_since) >= {16'd0, r_hold}) &&
                    ((r_late == '0) || ((r_ev - r_late) > {16'd0, r_hold}));
        w_step    = r_cur - r_tgt[7:0];
        w_dn      = (w_step > r_limit) ? r_cur - r_limit : r_tgt[7:0];
        w_next    = r_cur;
        w_stat    = ST_NORMAL;
        w_gs      = r_good_since;
        if (w_bad) begin
            w_stat = ST_BAD;
            if (r_tgt > {1'b0, r_max_size}) begin
                w_next = r_max_size;
            end else if (r_tgt < {1'b0, r_min}) begin
                w_next = r_min;
            end else begin
                w_next = r_tgt[7:0];
            end
        end else if (w_good) begin
            w_stat = ST_GOOD;
            if (r_status != ST_GOOD) begin
                w_gs = r_ev;
            end else if (w_hold_ok) begin
                w_next = (w_dn < r_min) ? r_min : w_dn;
                w_stat = ST_NORMAL;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in.valid) n_state = S_EXEC;
            S_EXEC: n_state = S_SCAN;
            S_SCAN: if (r_cnt == CNT_W'(WINDOW_DEPTH - 1))
                        n_state = (r_op == OP_QUERY) ? S_MUL : S_OUT;
            S_MUL:  n_state = S_DIV;
            S_DIV:  n_state = S_DEC;
            S_DEC:  n_state = S_OUT;
            S_OUT:  if (!r_ovld || o_out.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_min        <= '0;
            r_max_size   <= '0;
            r_hold       <= 16'd2000;
            r_limit      <= 8'd2;
            r_weight     <= 12'd256;
            r_last_ts    <= '0;
            r_last_arr   <= '0;
            r_sum        <= '0;
            r_fill       <= FILL_INIT;
            r_late       <= '0;
            r_good_since <= '0;
            r_status     <= ST_NORMAL;
            r_ovld       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_MIN_SIZE:   r_min      <= i_cfg.data[7:0];
                    REG_MAX_SIZE:   r_max_size <= i_cfg.data[7:0];
                    REG_HOLD_MS:    r_hold     <= i_cfg.data;
                    REG_STEP_LIMIT: r_limit    <= i_cfg.data[7:0];
                    REG_WEIGHT:     r_weight   <= i_cfg.data[11:0];
                    default: ;
                endcase
            end
            if (r_state == S_EXEC) begin
                case (r_op)
                    OP_PACKET: begin
                        r_last_ts  <= r_ts;
                        r_last_arr <= r_arr;
                        if (r_last_ts == '0) begin
                            r_fill <= FILL_INIT;
                        end else begin
                            r_sum <= w_sum;
                            if (!cb[WINDOW_DEPTH-1] && ($signed(r_fill) > $signed(w_sum)))
                                r_fill <= w_sum;
                        end
                    end
                    OP_LATE: r_late <= r_ev;
                    OP_RESET: begin
                        r_last_ts    <= '0;
                        r_last_arr   <= '0;
                        r_sum        <= '0;
                        r_fill       <= FILL_INIT;
                        r_late       <= '0;
                        r_good_since <= '0;
                        r_status     <= ST_NORMAL;
                    end
                    default: ;
                endcase
            end
            if (r_state == S_DEC) begin
                r_status     <= w_stat;
                r_good_since <= w_gs;
            end
            if (r_state == S_OUT && n_state == S_IDLE) begin
                r_ovld <= 1'b1;
            end else if (o_out.ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in.valid) begin
            r_op    <= i_in.opcode;
            r_ts    <= i_in.media_timestamp;
            r_arr   <= i_in.arrival_time;
            r_ev    <= i_in.event_time;
            r_cur   <= i_in.current_size;
            r_delta <= '0;
            r_next  <= '0;
        end
        if (r_state == S_EXEC) begin
            r_cnt  <= '0;
            r_have <= 1'b0;
            r_max  <= '0;
            if (w_push) r_delta <= w_delta;
        end
        if (r_state == S_SCAN) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (cb[WINDOW_DEPTH-1] &&
                (!r_have || ($signed(cv[WINDOW_DEPTH-1]) > $signed(r_max)))) begin
                r_max  <= cv[WINDOW_DEPTH-1];
                r_have <= 1'b1;
            end
        end
        if (r_state == S_MUL) r_prod <= $signed(r_max) * $signed({1'b0, r_weight});
        if (r_state == S_DIV) r_tgt <= w_tgt;
        if (r_state == S_DEC) r_next <= w_next;
        if (r_state == S_OUT && n_state == S_IDLE) begin
            r_odelta <= r_delta;
            r_onext  <= r_next;
            r_ostat  <= r_status;
            r_omax   <= r_max;
        end
    end

    assign o_out.valid         = r_ovld;
    assign o_out.transit_delta = $signed(r_odelta);
    assign o_out.next_size     = r_onext;
    assign o_out.link_status   = r_ostat;
    assign o_out.window_max    = $signed(r_omax);
endmodule

@@ hdl/jbs_chk.sv @@
// port checker for the jitter buffer sizer and its bind
module jbs_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_out_status,
    input logic [31:0] i_out_max
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_max))
        else $error("result word dropped while stalled");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("not idle after reset");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("word taken while busy");
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_status != 2'd3)
        else $error("bad link status code");
endmodule

bind adaptive_jitter_buffer_sizer_unit jbs_chk u_jbs_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_status (o_out.link_status),
    .i_out_max    (o_out.window_max)
);
